>>> rtl/core/cdo_pkg.sv
`default_nettype none
package cdo_pkg;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAYS_LONG = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB = 5'd28;

  localparam int unsigned YEAR_MAX = 9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;

  localparam logic [1:0] REG_BASE_DAY = 2'd0;
  localparam logic [1:0] REG_BASE_MONTH = 2'd1;
  localparam logic [1:0] REG_BASE_YEAR = 2'd2;

  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [1:0] year_lsb);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
      MONTH_FEB: len = (year_lsb == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
      default: len = DAYS_SHORT;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cdo_step.sv
`default_nettype none
module cdo_step import cdo_pkg::*; #(
  parameter int OFFSET_BITS = 21,
  parameter int YEAR_W = 23
) (
  input  wire logic signed [OFFSET_BITS-1:0] k_i,
  input  wire logic        [4:0]             day_i,
  input  wire logic        [3:0]             month_i,
  input  wire logic signed [YEAR_W-1:0]      year_i,
  output logic signed [OFFSET_BITS-1:0]      k_o,
  output logic        [4:0]                  day_o,
  output logic        [3:0]                  month_o,
  output logic signed [YEAR_W-1:0]           year_o
);

  logic        [4:0]           dim;
  logic        [4:0]           rest;
  logic signed [OFFSET_BITS:0] kx;
  logic signed [OFFSET_BITS:0] restx;
  logic signed [OFFSET_BITS:0] sum;
  logic        [3:0]           prev_month;
  logic signed [YEAR_W-1:0]    prev_year;

  always_comb begin
    dim = month_length(month_i, year_i[1:0]);
    rest = dim - day_i;
    kx = {k_i[OFFSET_BITS-1], k_i};
    restx = $signed({{(OFFSET_BITS-4){1'b0}}, rest});
    sum = kx + $signed({{(OFFSET_BITS-4){1'b0}}, day_i});
    if (month_i == MONTH_JAN) begin
      prev_month = MONTH_DEC;
      prev_year = year_i - YEAR_W'(1);
    end else begin
      prev_month = month_i - 4'd1;
      prev_year = year_i;
    end
    k_o = k_i;
    day_o = day_i;
    month_o = month_i;
    year_o = year_i;
    if (!k_i[OFFSET_BITS-1]) begin
      if (kx <= restx) begin
        day_o = day_i + k_i[4:0];
        k_o = '0;
      end else begin
        k_o = k_i - OFFSET_BITS'(rest) - OFFSET_BITS'(1);
        day_o = DAY_FIRST;
        if (month_i == MONTH_DEC) begin
          month_o = MONTH_JAN;
          year_o = year_i + YEAR_W'(1);
        end else begin
          month_o = month_i + 4'd1;
        end
      end
    end else begin
      if (sum > 0) begin
        day_o = sum[4:0];
        k_o = '0;
      end else begin
        k_o = sum[OFFSET_BITS-1:0];
        month_o = prev_month;
        year_o = prev_year;
        day_o = month_length(prev_month, prev_year[1:0]);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cdo_seq.sv
`default_nettype none
module cdo_seq import cdo_pkg::*; #(
  parameter int OFFSET_BITS = 21,
  parameter int YEAR_W = 23
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [OFFSET_BITS-1:0] offset_days,
  input  wire logic [4:0]             base_day,
  input  wire logic [3:0]             base_month,
  input  wire logic [13:0]            base_year,
  output logic                        busy,
  output logic                        res_valid,
  output logic [4:0]                  res_day,
  output logic [3:0]                  res_month,
  output logic [13:0]                 res_year,
  output logic                        res_overflow
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic                          state_r, state_nxt;
  logic signed [OFFSET_BITS-1:0] k_r, k_nxt;
  logic        [4:0]             day_r, day_nxt;
  logic        [3:0]             month_r, month_nxt;
  logic signed [YEAR_W-1:0]      year_r, year_nxt;
  logic                          valid_r, valid_nxt;
  logic        [4:0]             oday_r;
  logic        [3:0]             omonth_r;
  logic        [13:0]            oyear_r, oyear_nxt;
  logic                          oflow_r, oflow_nxt;

  logic signed [OFFSET_BITS-1:0] k_s;
  logic        [4:0]             day_s;
  logic        [3:0]             month_s;
  logic signed [YEAR_W-1:0]      year_s;
  logic        [3:0]             month_c;
  logic        [4:0]             dim_c;
  logic        [4:0]             day_c;
  logic                          load;
  logic                          finish;

  cdo_step #(.OFFSET_BITS(OFFSET_BITS), .YEAR_W(YEAR_W)) u_step (
    .k_i(k_r), .day_i(day_r), .month_i(month_r), .year_i(year_r),
    .k_o(k_s), .day_o(day_s), .month_o(month_s), .year_o(year_s)
  );

  always_comb begin
    if (base_month == 4'd0) begin
      month_c = MONTH_JAN;
    end else if (base_month > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = base_month;
    end
    dim_c = month_length(month_c, base_year[1:0]);
    if (base_day == 5'd0) begin
      day_c = DAY_FIRST;
    end else if (base_day > dim_c) begin
      day_c = dim_c;
    end else begin
      day_c = base_day;
    end

    load = (state_r == ST_IDLE) && start;
    finish = (state_r == ST_RUN) && (k_r == '0);

    state_nxt = state_r;
    k_nxt = k_r;
    day_nxt = day_r;
    month_nxt = month_r;
    year_nxt = year_r;
    valid_nxt = finish;
    if (load) begin
      state_nxt = ST_RUN;
      k_nxt = $signed(offset_days);
      day_nxt = day_c;
      month_nxt = month_c;
      year_nxt = $signed({{(YEAR_W-14){1'b0}}, base_year});
    end else if (finish) begin
      state_nxt = ST_IDLE;
    end else if (state_r == ST_RUN) begin
      k_nxt = k_s;
      day_nxt = day_s;
      month_nxt = month_s;
      year_nxt = year_s;
    end

    if (year_r[YEAR_W-1]) begin
      oyear_nxt = 14'd0;
      oflow_nxt = 1'b1;
    end else if (year_r > $signed(YEAR_W'(YEAR_MAX))) begin
      oyear_nxt = 14'(YEAR_MAX);
      oflow_nxt = 1'b1;
    end else begin
      oyear_nxt = year_r[13:0];
      oflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    day_r <= day_nxt;
    month_r <= month_nxt;
    year_r <= year_nxt;
    if (finish) begin
      oday_r <= day_r;
      omonth_r <= month_r;
      oyear_r <= oyear_nxt;
      oflow_r <= oflow_nxt;
    end
  end

  assign busy = (state_r == ST_RUN);
  assign res_valid = valid_r;
  assign res_day = oday_r;
  assign res_month = omonth_r;
  assign res_year = oyear_r;
  assign res_overflow = oflow_r;

endmodule
`default_nettype wire

>>> rtl/core/calendar_day_offset_top.sv
// Channel  Handshake            Payload
// in       start / busy         in_offset_days (signed day offset)
// out      out_valid (strobe)   out_day, out_month, out_year, out_year_overflow
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A transaction walks from the base date with the shared month-step unit: one step
// per month boundary crossed, plus one to settle the day unless the walk ends on a
// month edge, then the result is registered. busy drops as out_valid rises.
// rst_n is synchronous; reset loads the base date 2000-01-01.
// The receiver cannot stall; cfg_ready is always high.
`default_nettype none
module calendar_day_offset_top import cdo_pkg::*; #(
  parameter int OFFSET_BITS = 21
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [OFFSET_BITS-1:0] in_offset_days,
  output logic                        out_valid,
  output logic [4:0]                  out_day,
  output logic [3:0]                  out_month,
  output logic [13:0]                 out_year,
  output logic                        out_year_overflow,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [13:0]            cfg_data
);

  localparam int YEAR_W = ((OFFSET_BITS > 14) ? OFFSET_BITS : 14) + 2;

  logic [4:0]  base_day_r;
  logic [3:0]  base_month_r;
  logic [13:0] base_year_r;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_day_r <= DAY_FIRST;
      base_month_r <= MONTH_JAN;
      base_year_r <= YEAR_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_BASE_DAY: base_day_r <= cfg_data[4:0];
        REG_BASE_MONTH: base_month_r <= cfg_data[3:0];
        REG_BASE_YEAR: base_year_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cdo_seq #(.OFFSET_BITS(OFFSET_BITS), .YEAR_W(YEAR_W)) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .offset_days(in_offset_days),
    .base_day(base_day_r),
    .base_month(base_month_r),
    .base_year(base_year_r),
    .busy(busy),
    .res_valid(out_valid),
    .res_day(out_day),
    .res_month(out_month),
    .res_year(out_year),
    .res_overflow(out_year_overflow)
  );

endmodule
`default_nettype wire
